### rtl/core/sam_pkg.sv
// Package for the suffix automaton matcher: item codes, status codes,
// controller states and the result record. No dependencies.
`default_nettype none
package sam_pkg;

    localparam logic [1:0] K_CLEAR = 2'd0;
    localparam logic [1:0] K_TEXT  = 2'd1;
    localparam logic [1:0] K_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_E1, S_W1, S_C0, S_CPY, S_CPYW,
        S_R1, S_FIX, S_FIX2, S_FIN, S_Q1, S_Q2, S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] position;
    } t_res;

endpackage
`default_nettype wire

### rtl/core/suffix_automaton_matcher.sv
// Suffix automaton matcher: builds an automaton online from text beats and
// answers pattern queries against it.
//
// Input channel (i_in_valid / o_in_stall) carries kind, symbol and last. Kind 0
// clears the automaton, kind 1 appends a text symbol, kind 2 feeds one pattern
// symbol (last marks its end), kind 3 does nothing. Every input beat yields
// exactly one output beat (o_out_valid / i_out_stall) with status and position.
// One item is processed at a time; o_in_stall is high until it is done.
// Work per item: a query reads one transition, and on a found last symbol also
// the state record for its position, but nothing once its pattern has failed;
// a dropped or unused item goes straight to the response. An append writes the
// new state, walks suffix links, and checks lengths when the walk ends on an
// existing transition; a clone copies the whole transition row and checks each
// link for redirection, so item times vary; amortized appends stay short.
// A clear, and reset itself, sweeps the whole transition RAM invalid one entry
// per cycle; no item is taken meanwhile. The finished result sits in an output
// register, so the next item is accepted while it waits; if the receiver stalls,
// the block holds the result and stops at the end of the following item.
// Reset is synchronous and active low.
`default_nettype none
module suffix_automaton_matcher #(
    parameter int MAX_TEXT    = 256,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_kind,
    input  wire logic [7:0]             i_symbol,
    input  wire logic                   i_last,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_position
);
    import sam_pkg::*;

    localparam int SB  = SYMBOL_BITS;
    localparam int SW  = $clog2(2 * MAX_TEXT);
    localparam int TW  = $clog2(MAX_TEXT + 1);
    localparam int SDW = 2 * TW + SW;

    logic            out_free, load;
    t_res            res;
    logic            r_ovalid;
    t_res            r_ores;

    logic            tr_we;
    logic [SW+SB-1:0] tr_waddr, tr_raddr;
    logic [SW:0]     tr_wdata, tr_rdata;
    logic            sm_we;
    logic [SW-1:0]   sm_waddr, sm_raddr;
    logic [SDW-1:0]  sm_wdata, sm_rdata;

    // The output register frees when it is empty or is being taken this cycle.
    assign out_free = !r_ovalid || !i_out_stall;

    sam_ctrl #(
        .MAX_TEXT(MAX_TEXT), .SYMBOL_BITS(SB), .SW(SW), .TW(TW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .i_kind(i_kind), .i_sym(i_symbol[SB-1:0]),
        .i_last(i_last), .o_stall(o_in_stall),
        .i_out_free(out_free), .o_load(load), .o_res(res),
        .o_tr_we(tr_we), .o_tr_waddr(tr_waddr), .o_tr_wdata(tr_wdata),
        .o_tr_raddr(tr_raddr), .i_tr_rdata(tr_rdata),
        .o_sm_we(sm_we), .o_sm_waddr(sm_waddr), .o_sm_wdata(sm_wdata),
        .o_sm_raddr(sm_raddr), .i_sm_rdata(sm_rdata)
    );

    // Transition table: valid bit and target state per (state, symbol).
    sam_ram #(.AW(SW + SB), .DW(SW + 1)) u_trans (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(tr_wdata),
        .i_raddr(tr_raddr), .o_rdata(tr_rdata)
    );

    // Per-state record: length, suffix link, first end position.
    sam_ram #(.AW(SW), .DW(SDW)) u_state (
        .i_clk(i_clk), .i_we(sm_we), .i_waddr(sm_waddr), .i_wdata(sm_wdata),
        .i_raddr(sm_raddr), .o_rdata(sm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ores <= res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ores.status;
    assign o_position  = r_ores.position;
endmodule
`default_nettype wire

### rtl/core/sam_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// No dependencies.
`default_nettype none
module sam_ram #(
    parameter int AW = 9,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/sam_ctrl.sv
// Sequencer for the suffix automaton: construction walks, clone row copy,
// queries and table clearing. Depends on sam_pkg; drives two sam_ram instances.
`default_nettype none
module sam_ctrl #(
    parameter int MAX_TEXT    = 256,
    parameter int SYMBOL_BITS = 8,
    parameter int SW          = 9,
    parameter int TW          = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [1:0]               i_kind,
    input  wire logic [SYMBOL_BITS-1:0]   i_sym,
    input  wire logic                     i_last,
    output logic                          o_stall,
    input  wire logic                     i_out_free,
    output logic                          o_load,
    output sam_pkg::t_res                 o_res,
    output logic                          o_tr_we,
    output logic [SW+SYMBOL_BITS-1:0]     o_tr_waddr,
    output logic [SW:0]                   o_tr_wdata,
    output logic [SW+SYMBOL_BITS-1:0]     o_tr_raddr,
    input  wire logic [SW:0]              i_tr_rdata,
    output logic                          o_sm_we,
    output logic [SW-1:0]                 o_sm_waddr,
    output logic [2*TW+SW-1:0]            o_sm_wdata,
    output logic [SW-1:0]                 o_sm_raddr,
    input  wire logic [2*TW+SW-1:0]       i_sm_rdata
);
    import sam_pkg::*;

    localparam int SB  = SYMBOL_BITS;
    localparam int TAW = SW + SB;
    localparam int PW  = (TW + 1 > 8) ? TW + 1 : 8;

    t_state          r_st, n_st;
    logic [TAW-1:0]  r_cnt, n_cnt;
    logic            r_clr_rsp, n_clr_rsp;
    logic [SB-1:0]   r_sym, n_sym;
    logic            r_last, n_last;
    logic [SW-1:0]   r_scount, n_scount;
    logic [SW-1:0]   r_lastst, n_lastst;
    logic [TW-1:0]   r_text, n_text;
    logic [SW-1:0]   r_qst, n_qst;
    logic            r_qfail, n_qfail;
    logic [TW-1:0]   r_qlen, n_qlen;
    logic [SW-1:0]   r_nw, n_nw, r_cur, n_cur, r_nxt, n_nxt, r_cl, n_cl;
    logic [TW-1:0]   r_nwlen, n_nwlen, r_curlen, n_curlen;
    logic [TW-1:0]   r_nxtlen, n_nxtlen, r_nxtfe, n_nxtfe;
    logic [SB-1:0]   r_j, n_j, r_jd, n_jd;
    logic            r_cpv, n_cpv;
    t_res            r_res, n_res;

    logic            t_v;
    logic [SW-1:0]   t_tg;
    logic [TW-1:0]   s_len, s_fe;
    logic [SW-1:0]   s_link;
    logic [PW-1:0]   pos_full;

    assign t_v    = i_tr_rdata[SW];
    assign t_tg   = i_tr_rdata[SW-1:0];
    assign s_len  = i_sm_rdata[2*TW+SW-1 -: TW];
    assign s_link = i_sm_rdata[TW +: SW];
    assign s_fe   = i_sm_rdata[TW-1:0];
    assign pos_full = PW'(s_fe) + PW'(1) - PW'(r_qlen);

    assign o_stall = (r_st != S_IDLE);
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_CLR;
            r_cnt     <= '0;
            r_clr_rsp <= 1'b0;
            r_scount  <= SW'(1);
            r_lastst  <= '0;
            r_text    <= '0;
            r_qst     <= '0;
            r_qfail   <= 1'b0;
            r_qlen    <= '0;
            r_cpv     <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_cnt     <= n_cnt;
            r_clr_rsp <= n_clr_rsp;
            r_scount  <= n_scount;
            r_lastst  <= n_lastst;
            r_text    <= n_text;
            r_qst     <= n_qst;
            r_qfail   <= n_qfail;
            r_qlen    <= n_qlen;
            r_cpv     <= n_cpv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_nw     <= n_nw;
        r_cur    <= n_cur;
        r_nxt    <= n_nxt;
        r_cl     <= n_cl;
        r_nwlen  <= n_nwlen;
        r_curlen <= n_curlen;
        r_nxtlen <= n_nxtlen;
        r_nxtfe  <= n_nxtfe;
        r_j      <= n_j;
        r_jd     <= n_jd;
        r_res    <= n_res;
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_clr_rsp = r_clr_rsp; n_sym = r_sym;
        n_last = r_last; n_scount = r_scount; n_lastst = r_lastst; n_text = r_text;
        n_qst = r_qst; n_qfail = r_qfail; n_qlen = r_qlen; n_nw = r_nw;
        n_cur = r_cur; n_nxt = r_nxt; n_cl = r_cl; n_nwlen = r_nwlen;
        n_curlen = r_curlen; n_nxtlen = r_nxtlen; n_nxtfe = r_nxtfe;
        n_j = r_j; n_jd = r_jd; n_cpv = r_cpv; n_res = r_res;
        o_load = 1'b0;
        o_tr_we = 1'b0; o_tr_waddr = {r_cur, r_sym}; o_tr_wdata = '0;
        o_tr_raddr = {r_cur, r_sym};
        o_sm_we = 1'b0; o_sm_waddr = r_cur; o_sm_wdata = '0;
        o_sm_raddr = r_cur;
        case (r_st)
            S_CLR: begin
                // Sweep the transition table invalid and rewrite the root.
                o_tr_we = 1'b1;
                o_tr_waddr = r_cnt;
                o_sm_we = 1'b1;
                o_sm_waddr = '0;
                n_cnt = r_cnt + TAW'(1);
                if (r_cnt == '1) begin
                    n_st = r_clr_rsp ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                n_sym = i_sym;
                n_last = i_last;
                n_res = '{status: ST_OK, position: 8'd0};
                o_tr_raddr = {r_qst, i_sym};
                o_sm_raddr = r_lastst;
                n_cur = r_lastst;
                if (i_valid) begin
                    case (i_kind)
                        K_CLEAR: begin
                            n_scount = SW'(1); n_lastst = '0; n_text = '0;
                            n_qst = '0; n_qfail = 1'b0; n_qlen = '0;
                            n_cnt = '0; n_clr_rsp = 1'b1;
                            n_st = S_CLR;
                        end
                        K_TEXT: begin
                            n_qst = '0; n_qfail = 1'b0; n_qlen = '0;
                            if (r_text == TW'(MAX_TEXT)) begin
                                n_res.status = ST_FULL;
                                n_st = S_RESP;
                            end else begin
                                n_st = S_E1;
                            end
                        end
                        K_QUERY: begin
                            if (!r_qfail) begin
                                n_st = S_Q1;
                            end else begin
                                if (i_last) begin
                                    n_res.status = ST_MISS;
                                    n_qst = '0; n_qfail = 1'b0; n_qlen = '0;
                                end
                                n_st = S_RESP;
                            end
                        end
                        default: begin
                            n_st = S_RESP;
                        end
                    endcase
                end
            end
            S_E1: begin
                // Create the new state from the length of the previous last state.
                n_nw = r_scount;
                n_nwlen = s_len + TW'(1);
                n_scount = r_scount + SW'(1);
                o_sm_we = 1'b1;
                o_sm_waddr = r_scount;
                o_sm_wdata = {s_len + TW'(1), SW'(0), s_len};
                n_st = S_W1;
            end
            S_W1: begin
                if (t_v) begin
                    n_curlen = s_len;
                    n_nxt = t_tg;
                    o_sm_raddr = t_tg;
                    n_st = S_C0;
                end else begin
                    o_tr_we = 1'b1;
                    o_tr_wdata = {1'b1, r_nw};
                    if (r_cur == '0) begin
                        n_st = S_FIN;
                    end else begin
                        n_cur = s_link;
                        o_tr_raddr = {s_link, r_sym};
                        o_sm_raddr = s_link;
                    end
                end
            end
            S_C0: begin
                if (r_curlen + TW'(1) == s_len) begin
                    o_sm_we = 1'b1;
                    o_sm_waddr = r_nw;
                    o_sm_wdata = {r_nwlen, r_nxt, r_nwlen - TW'(1)};
                    n_st = S_FIN;
                end else begin
                    n_cl = r_scount;
                    n_scount = r_scount + SW'(1);
                    o_sm_we = 1'b1;
                    o_sm_waddr = r_scount;
                    o_sm_wdata = {r_curlen + TW'(1), s_link, s_fe};
                    n_nxtlen = s_len;
                    n_nxtfe = s_fe;
                    n_j = '0;
                    n_cpv = 1'b0;
                    n_st = S_CPY;
                end
            end
            S_CPY: begin
                // Row copy runs one read ahead of its write.
                o_tr_raddr = {r_nxt, r_j};
                o_tr_we = r_cpv;
                o_tr_waddr = {r_cl, r_jd};
                o_tr_wdata = i_tr_rdata;
                n_jd = r_j;
                n_cpv = 1'b1;
                n_j = r_j + SB'(1);
                if (r_j == '1) begin
                    n_st = S_CPYW;
                end
            end
            S_CPYW: begin
                o_tr_we = 1'b1;
                o_tr_waddr = {r_cl, r_jd};
                o_tr_wdata = i_tr_rdata;
                n_cpv = 1'b0;
                n_st = S_R1;
            end
            S_R1: begin
                if (!t_v || t_tg != r_nxt) begin
                    n_st = S_FIX;
                end else begin
                    o_tr_we = 1'b1;
                    o_tr_wdata = {1'b1, r_cl};
                    if (r_cur == '0) begin
                        n_st = S_FIX;
                    end else begin
                        n_cur = s_link;
                        o_tr_raddr = {s_link, r_sym};
                        o_sm_raddr = s_link;
                    end
                end
            end
            S_FIX: begin
                o_sm_we = 1'b1;
                o_sm_waddr = r_nxt;
                o_sm_wdata = {r_nxtlen, r_cl, r_nxtfe};
                n_st = S_FIX2;
            end
            S_FIX2: begin
                o_sm_we = 1'b1;
                o_sm_waddr = r_nw;
                o_sm_wdata = {r_nwlen, r_cl, r_nwlen - TW'(1)};
                n_st = S_FIN;
            end
            S_FIN: begin
                n_lastst = r_nw;
                n_text = r_text + TW'(1);
                n_st = S_RESP;
            end
            S_Q1: begin
                n_st = S_RESP;
                if (t_v) begin
                    n_qst = t_tg;
                    n_qlen = r_qlen + TW'(1);
                    o_sm_raddr = t_tg;
                    if (r_last) begin
                        n_st = S_Q2;
                    end
                end else if (r_last) begin
                    n_res.status = ST_MISS;
                    n_qst = '0; n_qfail = 1'b0; n_qlen = '0;
                end else begin
                    n_qfail = 1'b1;
                end
            end
            S_Q2: begin
                n_res.status = ST_FOUND;
                n_res.position = pos_full[7:0];
                n_qst = '0; n_qfail = 1'b0; n_qlen = '0;
                n_st = S_RESP;
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_load = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
